[src/turtle_pen_plotter_assert.svh]
// Assertion macros for the turtle pen plotter RTL.
// Uses the clk and rst_n names of the module that expands them.
`ifndef TURTLE_PEN_PLOTTER_ASSERT_SVH
`define TURTLE_PEN_PLOTTER_ASSERT_SVH

`ifndef SYNTHESIS
// Check prop at every rising edge outside reset.
`define TPP_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");
// Check that cond never holds.
`define TPP_ASSERT_NEVER(name, cond) \
    `TPP_ASSERT(name, !(cond))
`else
`define TPP_ASSERT(name, prop)
`define TPP_ASSERT_NEVER(name, cond)
`endif

`endif

[src/tpp_pkg.sv]
// Shared types and constants of the turtle pen plotter.
// No dependencies; imported by the controller, the datapath and the top level.
package tpp_pkg;

    localparam int DEF_MAX_ROWS = 32;
    localparam int DEF_MAX_COLS = 32;

    // Command codes
    localparam logic [2:0] FUNC_PEN_UP     = 3'd0;
    localparam logic [2:0] FUNC_PEN_DOWN   = 3'd1;
    localparam logic [2:0] FUNC_TURN_RIGHT = 3'd2;
    localparam logic [2:0] FUNC_TURN_LEFT  = 3'd3;
    localparam logic [2:0] FUNC_MOVE       = 3'd4;

    // Glyph codes
    localparam logic [1:0] GLYPH_BLANK    = 2'd0;
    localparam logic [1:0] GLYPH_TRAIL    = 2'd1;
    localparam logic [1:0] GLYPH_CUR_UP   = 2'd2;
    localparam logic [1:0] GLYPH_CUR_DOWN = 2'd3;

    // Headings
    localparam logic [1:0] HEAD_NORTH = 2'd0;
    localparam logic [1:0] HEAD_EAST  = 2'd1;
    localparam logic [1:0] HEAD_SOUTH = 2'd2;
    localparam logic [1:0] HEAD_WEST  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_NUM_ROWS = 2'd0;
    localparam logic [1:0] CFG_NUM_COLS = 2'd1;

    localparam logic [5:0] RST_NUM_ROWS = 6'd25;
    localparam logic [5:0] RST_NUM_COLS = 6'd32;
    localparam logic [4:0] RST_POS_ROW  = 5'd12;
    localparam logic [4:0] RST_POS_COL  = 5'd16;

    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] distance;
    } cmd_beat_t;

    typedef struct packed {
        logic [4:0] cell_row;
        logic [4:0] cell_col;
        logic [1:0] glyph;
        logic       last;
    } cell_beat_t;

    // Controller to datapath
    typedef struct packed {
        logic       capture;     // latch item, clamp position
        logic       pen_write;
        logic       pen_value;   // 1 raised
        logic       turn_right;
        logic       turn_left;
        logic       load_count;
        logic       step_one;    // one cell, count down
        logic       jump;        // run to end of count or edge
        logic       final_step;  // one cell unless at edge
        logic       emit;
        logic [1:0] emit_glyph;
        logic       emit_last;
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [2:0] func;
        logic       pen_raised;
        logic       at_edge;
        logic       count_zero;
        logic       out_free;
    } ctl_status_t;

endpackage

[src/tpp_ctrl.sv]
// Sequencer of the turtle pen plotter: decodes a command and walks a move.
// Depends on tpp_pkg and turtle_pen_plotter_assert.svh.
`include "turtle_pen_plotter_assert.svh"

module tpp_ctrl
    import tpp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  ctl_status_t status,
    output ctl_cmd_t    ctl
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DECODE = 4'b0010,
        S_WALK   = 4'b0100,
        S_FINAL  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign cmd_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (status.func)
                    FUNC_PEN_UP:
                    begin
                        if (status.out_free)
                        begin
                            ctl.pen_write  = 1'b1;
                            ctl.pen_value  = 1'b1;
                            ctl.emit       = 1'b1;
                            ctl.emit_glyph = GLYPH_CUR_UP;
                            ctl.emit_last  = 1'b1;
                            state_next     = S_IDLE;
                        end
                    end
                    FUNC_PEN_DOWN:
                    begin
                        if (status.out_free)
                        begin
                            ctl.pen_write  = 1'b1;
                            ctl.pen_value  = 1'b0;
                            ctl.emit       = 1'b1;
                            ctl.emit_glyph = GLYPH_CUR_DOWN;
                            ctl.emit_last  = 1'b1;
                            state_next     = S_IDLE;
                        end
                    end
                    FUNC_TURN_RIGHT:
                    begin
                        ctl.turn_right = 1'b1;
                        state_next     = S_IDLE;
                    end
                    FUNC_TURN_LEFT:
                    begin
                        ctl.turn_left = 1'b1;
                        state_next    = S_IDLE;
                    end
                    FUNC_MOVE:
                    begin
                        if (status.out_free)
                        begin
                            ctl.emit       = 1'b1;
                            ctl.emit_glyph = status.pen_raised ? GLYPH_BLANK : GLYPH_TRAIL;
                            ctl.load_count = 1'b1;
                            state_next     = S_WALK;
                        end
                    end
                    default:
                    begin
                        // drop unknown codes
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_WALK:
            begin
                if (status.count_zero || status.at_edge)
                begin
                    state_next = S_FINAL;
                end
                else if (status.pen_raised)
                begin
                    // nothing to draw: advance in one go
                    ctl.jump = 1'b1;
                end
                else if (status.out_free)
                begin
                    ctl.step_one   = 1'b1;
                    ctl.emit       = 1'b1;
                    ctl.emit_glyph = GLYPH_TRAIL;
                end
            end
            S_FINAL:
            begin
                if (status.out_free)
                begin
                    ctl.final_step = 1'b1;
                    ctl.emit       = 1'b1;
                    ctl.emit_glyph = status.pen_raised ? GLYPH_CUR_UP : GLYPH_CUR_DOWN;
                    ctl.emit_last  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `TPP_ASSERT(a_emit_needs_room, ctl.emit |-> status.out_free)
    `TPP_ASSERT(a_last_ends_cmd, (ctl.emit && ctl.emit_last) |=> (state_reg == S_IDLE))

endmodule

[src/tpp_datapath.sv]
// Datapath of the turtle pen plotter: grid registers, turtle state, step
// counter and the output register. Depends on tpp_pkg and the assert header.
`include "turtle_pen_plotter_assert.svh"

module tpp_datapath
    import tpp_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_beat_t   cmd,
    input  logic        cfg_valid,
    input  logic [1:0]  cfg_index,
    input  logic [5:0]  cfg_data,
    input  ctl_cmd_t    ctl,
    output ctl_status_t status,
    output logic        cell_valid,
    input  logic        cell_stall,
    output cell_beat_t  cell_data
);

    localparam int ROW_LIM = (MAX_ROWS < 32) ? MAX_ROWS : 32;
    localparam int COL_LIM = (MAX_COLS < 32) ? MAX_COLS : 32;
    localparam logic [5:0] ROW_LIM_V = 6'(ROW_LIM);
    localparam logic [5:0] COL_LIM_V = 6'(COL_LIM);
    localparam logic [5:0] DIM_MIN   = 6'd3;

    logic [5:0]  num_rows_reg;
    logic [5:0]  num_cols_reg;
    logic [4:0]  pos_row_reg, pos_row_next;
    logic [4:0]  pos_col_reg, pos_col_next;
    logic        pen_raised_reg;
    logic [1:0]  heading_reg;
    logic [15:0] count_reg, count_next;
    logic [2:0]  func_reg;
    logic [15:0] distance_reg;
    logic        cell_valid_reg;
    cell_beat_t  cell_reg;

    logic [5:0]  rows_eff, cols_eff, rows_dec, cols_dec;
    logic [4:0]  rows_m1, cols_m1;
    logic [4:0]  room, amount;
    logic        at_edge, count_zero, out_free, move_en;

    // Effective grid size and last row / column
    always_comb
    begin
        if (num_rows_reg < DIM_MIN)
            rows_eff = DIM_MIN;
        else if (num_rows_reg > ROW_LIM_V)
            rows_eff = ROW_LIM_V;
        else
            rows_eff = num_rows_reg;
        if (num_cols_reg < DIM_MIN)
            cols_eff = DIM_MIN;
        else if (num_cols_reg > COL_LIM_V)
            cols_eff = COL_LIM_V;
        else
            cols_eff = num_cols_reg;
        rows_dec = rows_eff - 6'd1;
        cols_dec = cols_eff - 6'd1;
    end

    assign rows_m1 = rows_dec[4:0];
    assign cols_m1 = cols_dec[4:0];

    // Cells left before the edge in the current heading
    always_comb
    begin
        case (heading_reg)
            HEAD_NORTH: room = pos_row_reg;
            HEAD_EAST:  room = cols_m1 - pos_col_reg;
            HEAD_SOUTH: room = rows_m1 - pos_row_reg;
            HEAD_WEST:  room = pos_col_reg;
            default:    room = 5'd0;
        endcase
    end

    assign at_edge    = (room == 5'd0);
    assign count_zero = (count_reg == 16'd0);
    assign out_free   = !cell_valid_reg || !cell_stall;

    always_comb
    begin
        if (ctl.jump)
            amount = (count_reg < {11'd0, room}) ? count_reg[4:0] : room;
        else
            amount = 5'd1;
        move_en = ctl.jump || ctl.step_one || (ctl.final_step && !at_edge);
    end

    always_comb
    begin
        pos_row_next = pos_row_reg;
        pos_col_next = pos_col_reg;
        if (ctl.capture)
        begin
            if (pos_row_reg > rows_m1)
                pos_row_next = rows_m1;
            if (pos_col_reg > cols_m1)
                pos_col_next = cols_m1;
        end
        else if (move_en)
        begin
            case (heading_reg)
                HEAD_NORTH: pos_row_next = pos_row_reg - amount;
                HEAD_EAST:  pos_col_next = pos_col_reg + amount;
                HEAD_SOUTH: pos_row_next = pos_row_reg + amount;
                HEAD_WEST:  pos_col_next = pos_col_reg - amount;
                default:    pos_row_next = pos_row_reg;
            endcase
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctl.load_count)
            count_next = (distance_reg == 16'd0) ? 16'd0 : distance_reg - 16'd1;
        else if (ctl.step_one)
            count_next = count_reg - 16'd1;
        else if (ctl.jump)
            count_next = 16'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg   <= RST_NUM_ROWS;
            num_cols_reg   <= RST_NUM_COLS;
            pos_row_reg    <= RST_POS_ROW;
            pos_col_reg    <= RST_POS_COL;
            pen_raised_reg <= 1'b1;
            heading_reg    <= HEAD_NORTH;
            count_reg      <= 16'd0;
            cell_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && (cfg_index == CFG_NUM_ROWS))
                num_rows_reg <= cfg_data;
            if (cfg_valid && (cfg_index == CFG_NUM_COLS))
                num_cols_reg <= cfg_data;
            pos_row_reg <= pos_row_next;
            pos_col_reg <= pos_col_next;
            if (ctl.pen_write)
                pen_raised_reg <= ctl.pen_value;
            if (ctl.turn_right)
                heading_reg <= heading_reg + 2'd1;
            else if (ctl.turn_left)
                heading_reg <= heading_reg - 2'd1;
            count_reg <= count_next;
            if (ctl.emit)
                cell_valid_reg <= 1'b1;
            else if (!cell_stall)
                cell_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            func_reg     <= cmd.func;
            distance_reg <= cmd.distance;
        end
        if (ctl.emit)
        begin
            cell_reg.cell_row <= pos_row_next;
            cell_reg.cell_col <= pos_col_next;
            cell_reg.glyph    <= ctl.emit_glyph;
            cell_reg.last     <= ctl.emit_last;
        end
    end

    assign status.func       = func_reg;
    assign status.pen_raised = pen_raised_reg;
    assign status.at_edge    = at_edge;
    assign status.count_zero = count_zero;
    assign status.out_free   = out_free;

    assign cell_valid = cell_valid_reg;
    assign cell_data  = cell_reg;

    `TPP_ASSERT_NEVER(a_step_past_edge, (ctl.step_one || ctl.jump) && (at_edge || count_zero))
    `TPP_ASSERT(a_count_falls, (!ctl.load_count && !ctl.capture) |=> (count_reg <= $past(count_reg)))

endmodule

[src/turtle_pen_plotter.sv]
// Turtle pen plotter: turns pen, turn and move commands into cell writes.
// A pen command gives a single write on decode; a turn gives no write.
// A move writes on decode, then, pen down, one trail write per cycle on the walk,
// then a last write (up to 33 writes); a raised-pen walk jumps in one go.
// One command at a time; output stalls stretch each write. Reset is async,
// active low: grid 25 by 32, turtle at row 12 column 16, pen up, facing north.
module turtle_pen_plotter
    import tpp_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_stall,
    input  cmd_beat_t  cmd,
    output logic       cell_valid,
    input  logic       cell_stall,
    output cell_beat_t cell_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [5:0] cfg_data
);

    ctl_cmd_t    ctl;
    ctl_status_t status;

    assign cfg_ready = 1'b1;

    tpp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .status    (status),
        .ctl       (ctl)
    );

    tpp_datapath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cfg_valid  (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .ctl        (ctl),
        .status     (status),
        .cell_valid (cell_valid),
        .cell_stall (cell_stall),
        .cell_data  (cell_data)
    );

endmodule
